// ===== rtl/uart_tick_sampled_transceiver_unit_macros.svh =====
// Assertion macros for the UART tick-sampled transceiver.
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef UART_TICK_SAMPLED_TRANSCEIVER_UNIT_MACROS_SVH
`define UART_TICK_SAMPLED_TRANSCEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utst assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UTST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utst assertion failed");

`endif

// ===== rtl/utst_pkg.sv =====
// Shared types and constants for the UART tick-sampled transceiver.
// No dependencies; every RTL module imports this package.
package utst_pkg;

  localparam int PERIOD_WIDTH     = 12;
  localparam int CFG_PERIOD_WIDTH = 12;
  localparam int APB_ADDR_WIDTH   = 3;
  localparam int APB_DATA_WIDTH   = 32;
  localparam int RX_FRAME_WIDTH   = 10;
  localparam int TX_FRAME_WIDTH   = 11;

  localparam logic [PERIOD_WIDTH-1:0]   BIT_PERIOD_RESET = PERIOD_WIDTH'(52);
  localparam logic [3:0]                RX_SAMPLES       = 4'd10;
  localparam logic [RX_FRAME_WIDTH-1:0] FRAME_CHECK_MASK = 10'h201;
  localparam logic [RX_FRAME_WIDTH-1:0] FRAME_CHECK_GOOD = 10'h200;
  localparam logic [3:0]                TX_FRAME_BITS    = 4'd11;
  localparam logic [TX_FRAME_WIDTH-1:0] TX_SHIFT_IDLE    = 11'h7FF;
  localparam logic [1:0]                TX_STOP_BITS     = 2'b11;

  // Receive status codes.
  localparam logic [2:0] RX_STATUS_IDLE  = 3'd0;
  localparam logic [2:0] RX_STATUS_BUSY  = 3'd1;
  localparam logic [2:0] RX_STATUS_GOOD  = 3'd2;
  localparam logic [2:0] RX_STATUS_FRAME = 3'd3;
  localparam logic [2:0] RX_STATUS_OFF   = 3'd4;

  // Register indexes, taken from address bit 2.
  localparam logic REG_BIT_PERIOD = 1'b0;
  localparam logic REG_ENABLED    = 1'b1;

  typedef struct packed {
    logic       rx_level;
    logic       tx_start;
    logic [7:0] tx_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_level;
    logic       tx_busy;
    logic [2:0] rx_status;
    logic [7:0] rx_data;
  } out_word_t;

  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] bit_period;
    logic                    enabled;
  } cfg_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
  } rx_result_t;

  typedef struct packed {
    logic level;
    logic busy;
  } tx_result_t;

endpackage

// ===== rtl/utst_apb_regs.sv =====
// APB register file holding the bit period and the enable flag.
// Depends on utst_pkg.
module utst_apb_regs
  import utst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  logic [PERIOD_WIDTH-1:0] bit_period;
  logic                    enabled;
  logic                    reg_index;
  logic                    wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= BIT_PERIOD_RESET;
      enabled    <= 1'b0;
    end else if (wr_en) begin
      case (reg_index)
        REG_BIT_PERIOD: bit_period <= PERIOD_WIDTH'(pwdata[CFG_PERIOD_WIDTH-1:0]);
        REG_ENABLED:    enabled    <= pwdata[0];
        default:        enabled    <= enabled;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_BIT_PERIOD: prdata = APB_DATA_WIDTH'(bit_period);
      REG_ENABLED:    prdata = APB_DATA_WIDTH'(enabled);
      default:        prdata = '0;
    endcase
  end

  assign cfg.bit_period = bit_period;
  assign cfg.enabled    = enabled;

endmodule

// ===== rtl/utst_rx.sv =====
// Receiver: start detection, half-period preset, ten samples and frame check.
// Depends on utst_pkg.
module utst_rx
  import utst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cfg_t       cfg,
  input  logic       rx_level,
  output rx_result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ,
    PH_DONE
  } phase_t;

  phase_t                    phase, phase_next;
  logic [PERIOD_WIDTH-1:0]   elapsed, elapsed_next;
  logic [RX_FRAME_WIDTH-1:0] shift, shift_next;
  logic [3:0]                bit_count, bit_count_next;
  logic [PERIOD_WIDTH-1:0]   elapsed_inc;
  logic [3:0]                count_inc;

  assign elapsed_inc = elapsed + PERIOD_WIDTH'(1);
  assign count_inc   = bit_count + 4'd1;

  always_comb begin
    phase_next     = phase;
    elapsed_next   = elapsed;
    shift_next     = shift;
    bit_count_next = bit_count;
    res.status     = RX_STATUS_IDLE;
    res.data       = 8'd0;
    if (!cfg.enabled) begin
      phase_next     = PH_IDLE;
      elapsed_next   = '0;
      shift_next     = '0;
      bit_count_next = '0;
      res.status     = RX_STATUS_OFF;
    end else begin
      case (phase)
        PH_READ: begin
          res.status   = RX_STATUS_BUSY;
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= cfg.bit_period) begin
            if (bit_count < RX_SAMPLES) begin
              shift_next = shift | (RX_FRAME_WIDTH'(rx_level) << bit_count);
            end
            bit_count_next = count_inc;
            elapsed_next   = elapsed_inc - cfg.bit_period;
            if (count_inc >= RX_SAMPLES) begin
              phase_next = PH_DONE;
            end
          end
        end
        PH_DONE: begin
          // The line is not looked at on the report tick.
          phase_next = PH_IDLE;
          if ((shift & FRAME_CHECK_MASK) != FRAME_CHECK_GOOD) begin
            res.status = RX_STATUS_FRAME;
          end else begin
            res.status = RX_STATUS_GOOD;
            res.data   = shift[8:1];
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (!rx_level) begin
            res.status     = RX_STATUS_BUSY;
            elapsed_next   = cfg.bit_period >> 1;
            shift_next     = '0;
            bit_count_next = '0;
            phase_next     = PH_READ;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      elapsed   <= '0;
      shift     <= '0;
      bit_count <= '0;
    end else if (step) begin
      phase     <= phase_next;
      elapsed   <= elapsed_next;
      shift     <= shift_next;
      bit_count <= bit_count_next;
    end
  end

endmodule

// ===== rtl/utst_tx.sv =====
// Transmitter: shifts out start, eight data and two stop bits at the bit period.
// Depends on utst_pkg.
module utst_tx
  import utst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cfg_t       cfg,
  input  logic       tx_start,
  input  logic [7:0] tx_byte,
  output tx_result_t res
);

  logic [TX_FRAME_WIDTH-1:0] shift, shift_next;
  logic [3:0]                bits_left, bits_left_next;
  logic [PERIOD_WIDTH-1:0]   elapsed, elapsed_next;
  logic [PERIOD_WIDTH-1:0]   elapsed_inc;

  assign elapsed_inc = elapsed + PERIOD_WIDTH'(1);

  always_comb begin
    shift_next     = shift;
    bits_left_next = bits_left;
    elapsed_next   = elapsed;
    if (!cfg.enabled) begin
      shift_next     = TX_SHIFT_IDLE;
      bits_left_next = '0;
      elapsed_next   = '0;
    end else begin
      if (bits_left != 4'd0) begin
        elapsed_next = elapsed_inc;
        if (elapsed_inc >= cfg.bit_period) begin
          elapsed_next   = elapsed_inc - cfg.bit_period;
          shift_next     = {1'b1, shift[TX_FRAME_WIDTH-1:1]};
          bits_left_next = bits_left - 4'd1;
        end
      end
      // A frame that ends on this tick lets a new request start at once.
      if (bits_left_next == 4'd0 && tx_start) begin
        shift_next     = {TX_STOP_BITS, tx_byte, 1'b0};
        bits_left_next = TX_FRAME_BITS;
        elapsed_next   = '0;
      end
    end
  end

  assign res.level = shift_next[0];
  assign res.busy  = (bits_left_next != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift     <= TX_SHIFT_IDLE;
      bits_left <= '0;
      elapsed   <= '0;
    end else if (step) begin
      shift     <= shift_next;
      bits_left <= bits_left_next;
      elapsed   <= elapsed_next;
    end
  end

endmodule

// ===== rtl/uart_tick_sampled_transceiver_unit.sv =====
// Top level of the UART tick-sampled transceiver: registers, rx, tx and result register.
// Depends on utst_pkg, utst_apb_regs, utst_rx, utst_tx and the assertion macro header.
//
//   Channel  | Direction | Handshake             | Word
//   ---------+-----------+-----------------------+------------------------------
//   in       | input     | in_valid / in_ready   | in_word  (one timer tick)
//   out      | output    | out_valid / out_ready | out_word (line and rx status)
//   apb      | input     | psel / penable        | paddr, pwdata, prdata
//
// Each accepted tick gives one result word in the next cycle; one tick per cycle sustained while out_ready is high.
// The receiver and transmitter state advance in the accepting cycle; the result register
// holds the word until it is taken, and a new tick is accepted in the same cycle.
// Reset returns both sides to idle with the port disabled and a bit period of 52.
// A stall on the output only stops input acceptance while the result register is full.
`include "uart_tick_sampled_transceiver_unit_macros.svh"

module uart_tick_sampled_transceiver_unit
  import utst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_word_t                  in_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_word_t                 out_word,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  cfg_t       cfg;
  rx_result_t rx_res;
  tx_result_t tx_res;
  logic       step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  utst_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  utst_rx u_rx (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cfg      (cfg),
    .rx_level (in_word.rx_level),
    .res      (rx_res)
  );

  utst_tx u_tx (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cfg      (cfg),
    .tx_start (in_word.tx_start),
    .tx_byte  (in_word.tx_byte),
    .res      (tx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word.tx_level  <= tx_res.level;
      out_word.tx_busy   <= tx_res.busy;
      out_word.rx_status <= rx_res.status;
      out_word.rx_data   <= rx_res.data;
    end
  end

  `UTST_ASSERT_NEXT(a_accept_gives_word, step, out_valid)
  `UTST_ASSERT_SAME(a_idle_line_high, out_valid && !out_word.tx_busy, out_word.tx_level)
  `UTST_ASSERT_SAME(a_data_only_when_good,
                    out_valid && (out_word.rx_status != RX_STATUS_GOOD),
                    out_word.rx_data == 8'd0)
  `UTST_ASSERT_SAME(a_off_is_quiet, out_valid && (out_word.rx_status == RX_STATUS_OFF),
                    !out_word.tx_busy)

endmodule
